/* rtl/altitude_pid_thrust_controller_core_defines.svh */
// Assertion macros for the altitude PID thrust controller core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ALTITUDE_PID_THRUST_CONTROLLER_CORE_DEFINES_SVH
`define ALTITUDE_PID_THRUST_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define APTC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("aptc check failed: forbidden condition");
`define APTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aptc check failed: expected follow-up missing");
`else
`define APTC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define APTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/aptc_pkg.sv */
// Shared constants, types and saturation helpers for the altitude PID core.
// No dependencies; used by every other file of the block but the defines header.
`timescale 1ns / 1ps
`default_nettype none
package aptc_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int TILT_W    = 18;
    localparam int DT_W      = 17;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int MUL_Q_W   = PROD_W - FRAC_W;
    localparam int ACC_W     = 36;
    localparam int DIV_NUM_W = ACC_W + FRAC_W;
    localparam int DIV_DEN_W = TILT_W;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] K_RATE    = 32'sd2621;
    localparam logic signed [DATA_W-1:0] K_GRAVITY = 32'sd642908;
    localparam logic signed [DATA_W-1:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN   = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0] Q_ROUND   = (64'sd1 <<< FRAC_W) - 64'sd1;

    localparam logic [CFG_W-1:0] RST_RATE_LIMIT = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_MASS       = 31'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ASCENT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_MASS  = 3'd5;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_Q_W-1:0] q;
    } t_mul_res;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic                     ovf;
        logic signed [DATA_W-1:0] q;
    } t_div_res;

    // Clamp to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < PROD_W'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic ovf32(input logic signed [PROD_W-1:0] v);
        return (v > PROD_W'(S32_MAX)) || (v < PROD_W'(S32_MIN));
    endfunction

endpackage
`default_nettype wire

/* rtl/aptc_if.sv */
// Valid/ready channel interfaces of the altitude PID core: tick input,
// thrust output and register write. Depends on aptc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface aptc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [aptc_pkg::DATA_W-1:0]        target_height;
    logic signed [aptc_pkg::DATA_W-1:0]        target_climb_speed;
    logic signed [aptc_pkg::DATA_W-1:0]        measured_height;
    logic signed [aptc_pkg::DATA_W-1:0]        measured_climb_speed;
    logic signed [aptc_pkg::TILT_W-1:0]        tilt_cosine;
    logic signed [aptc_pkg::DATA_W-1:0]        feedforward_accel;
    logic        [aptc_pkg::DT_W-1:0]          time_step;

    modport source (
        output valid, target_height, target_climb_speed, measured_height,
               measured_climb_speed, tilt_cosine, feedforward_accel, time_step,
        input  ready
    );
    modport sink (
        input  valid, target_height, target_climb_speed, measured_height,
               measured_climb_speed, tilt_cosine, feedforward_accel, time_step,
        output ready
    );
endinterface

interface aptc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [aptc_pkg::DATA_W-1:0] thrust_out;
    logic                               saturated;

    modport source (output valid, thrust_out, saturated, input ready);
    modport sink   (input valid, thrust_out, saturated, output ready);
endinterface

interface aptc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aptc_pkg::CFG_IDX_W-1:0]   index;
    logic [aptc_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/aptc_mul.sv */
// Shared two-stage Q16.16 multiplier: 32x32 signed product, then a
// truncate-toward-zero scale by 2^-16. Depends on aptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aptc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aptc_pkg::t_mul_req i_req,
    output aptc_pkg::t_mul_res o_res
);

    logic signed [aptc_pkg::PROD_W-1:0]  w_prod;
    logic signed [aptc_pkg::PROD_W-1:0]  w_adj;
    logic signed [aptc_pkg::PROD_W-1:0]  r_prod;
    logic signed [aptc_pkg::MUL_Q_W-1:0] r_q;
    logic                                r_v1;
    logic                                r_done;

    assign w_prod = i_req.a * i_req.b;
    // bias negative products so the shift truncates toward zero
    assign w_adj  = r_prod + (r_prod[aptc_pkg::PROD_W-1] ? aptc_pkg::Q_ROUND
                                                         : {aptc_pkg::PROD_W{1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_req.start;
            r_done <= r_v1;
        end
        r_prod <= w_prod;
        r_q    <= w_adj[aptc_pkg::PROD_W-1:aptc_pkg::FRAC_W];
    end

    assign o_res.done = r_done;
    assign o_res.q    = r_q;

endmodule
`default_nettype wire

/* rtl/aptc_div.sv */
// Shared signed divider: restoring, two quotient bits a cycle, quotient
// truncated toward zero and saturated to 32 bits. Depends on aptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aptc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aptc_pkg::t_div_req i_req,
    output aptc_pkg::t_div_res o_res
);

    localparam int NW = aptc_pkg::DIV_NUM_W;
    localparam int DW = aptc_pkg::DIV_DEN_W;
    localparam int CW = aptc_pkg::DIV_CNT_W;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate                          r_state, n_state;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [NW-1:0]                    r_dvd, n_dvd;
    logic [DW-1:0]                    r_rem, n_rem;
    logic [DW-1:0]                    r_den, n_den;
    logic                             r_neg, n_neg;
    logic                             r_done, n_done;
    logic                             r_ovf, n_ovf;
    logic signed [aptc_pkg::DATA_W-1:0] r_q, n_q;

    logic [DW:0]   w_t1, w_t2;
    logic [DW-1:0] w_rem1, w_rem2;
    logic [NW-1:0] w_dvd1, w_dvd2;
    logic          w_ge1, w_ge2;
    logic [NW-1:0] w_nabs;
    logic [DW-1:0] w_dabs;

    assign w_nabs = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
    assign w_dabs = i_req.den[DW-1] ? DW'(-i_req.den) : DW'(i_req.den);

    // two restoring steps per cycle
    always_comb begin
        w_t1   = {r_rem, r_dvd[NW-1]};
        w_ge1  = (w_t1 >= {1'b0, r_den});
        w_rem1 = w_ge1 ? DW'(w_t1 - {1'b0, r_den}) : DW'(w_t1);
        w_dvd1 = {r_dvd[NW-2:0], w_ge1};
        w_t2   = {w_rem1, w_dvd1[NW-1]};
        w_ge2  = (w_t2 >= {1'b0, r_den});
        w_rem2 = w_ge2 ? DW'(w_t2 - {1'b0, r_den}) : DW'(w_t2);
        w_dvd2 = {w_dvd1[NW-2:0], w_ge2};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_q     = r_q;
        case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_dvd   = w_nabs;
                    n_den   = w_dabs;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg   = i_req.num[NW-1] ^ i_req.den[DW-1];
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_dvd = w_dvd2;
                n_rem = w_rem2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(aptc_pkg::DIV_STEPS - 1)) begin
                    n_state = D_FIN;
                end
            end
            D_FIN: begin
                n_done  = 1'b1;
                n_state = D_IDLE;
                if (r_neg) begin
                    n_ovf = (r_dvd > NW'(64'h8000_0000));
                    n_q   = n_ovf ? aptc_pkg::S32_MIN : -$signed(r_dvd[aptc_pkg::DATA_W-1:0]);
                end else begin
                    n_ovf = (r_dvd > NW'(64'h7FFF_FFFF));
                    n_q   = n_ovf ? aptc_pkg::S32_MAX : $signed(r_dvd[aptc_pkg::DATA_W-1:0]);
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_ovf <= n_ovf;
        r_q   <= n_q;
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.q    = r_q;

endmodule
`default_nettype wire

/* rtl/altitude_pid_thrust_controller_core.sv */
// Altitude PID thrust controller: sequencer, registers and loop state.
// Depends on aptc_pkg, aptc_if, aptc_mul, aptc_div and the defines header.
//
// Usage:
//   i_cfg  - register writes (index 0..5: position, velocity, integral gain,
//            descent and ascent rate limit, vehicle mass). Always ready; write
//            only while no tick is in flight. Indexes 6 and 7 are ignored.
//   i_in   - one beat per control tick (targets, measurements, tilt cosine,
//            feed-forward, time step). Ready only while the sequencer idles.
//   o_out  - one beat per tick: thrust in Q16.16 newtons and a saturation flag.
// Sequencing: one tick runs through one shared multiplier and one shared
//   divider (two quotient bits a cycle). With a nonzero time step the rate
//   division overlaps the first four products. A zero tilt cosine skips the
//   second division and the mass product.
// Stall: the result sits in an output register; the next tick is accepted
//   while it waits, and the sequencer holds at its last step until the
//   output register frees.
// Reset: synchronous, active low. Clears the integrator and last position
//   error, loads the register reset values and drops any pending beat.
`timescale 1ns / 1ps
`default_nettype none
`include "altitude_pid_thrust_controller_core_defines.svh"
module altitude_pid_thrust_controller_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aptc_in_if.sink           i_in,
    aptc_out_if.source        o_out,
    aptc_cfg_if.sink          i_cfg
);

    localparam int DW  = aptc_pkg::DATA_W;
    localparam int PW  = aptc_pkg::PROD_W;
    localparam int AW  = aptc_pkg::ACC_W;
    localparam int NW  = aptc_pkg::DIV_NUM_W;
    localparam int FW  = aptc_pkg::FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ERR, S_VERR, S_MUL, S_RATE, S_NUM, S_UDIV, S_OUT
    } t_state;

    // which product the multiplier is working on
    typedef enum logic [2:0] {
        OP_INT, OP_KP, OP_KV, OP_KI, OP_KR, OP_MASS
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // configuration
    logic [aptc_pkg::CFG_W-1:0] r_kp, n_kp, r_kv, n_kv, r_ki, n_ki;
    logic [aptc_pkg::CFG_W-1:0] r_desc, n_desc, r_asc, n_asc, r_mass, n_mass;

    // captured tick
    logic signed [DW-1:0]              r_th, n_th, r_tv, n_tv, r_mh, n_mh, r_mv, n_mv;
    logic signed [DW-1:0]              r_ff, n_ff;
    logic signed [aptc_pkg::TILT_W-1:0] r_bz, n_bz;
    logic [aptc_pkg::DT_W-1:0]         r_dt, n_dt;

    // working values and loop state
    logic signed [DW-1:0] r_err, n_err, r_vcmd, n_vcmd, r_verr, n_verr;
    logic signed [DW-1:0] r_integral, n_integral, r_last, n_last;
    logic signed [DW-1:0] r_rate, n_rate;
    logic                 r_rate_ok, n_rate_ok;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_sat, n_sat;

    // shared unit requests
    aptc_pkg::t_mul_req r_mreq, n_mreq;
    aptc_pkg::t_div_req r_dreq, n_dreq;
    aptc_pkg::t_mul_res w_mres;
    aptc_pkg::t_div_res w_dres;

    // output register
    logic                 r_ovalid, n_ovalid;
    logic signed [DW-1:0] r_othrust, n_othrust;
    logic                 r_osat, n_osat;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic signed [DW-1:0] w_mq_sat;
    logic                 w_mq_ovf;
    logic signed [PW-1:0] w_int_sum;
    logic signed [PW-1:0] w_neg_mq;
    logic signed [PW-1:0] w_err_d;
    logic signed [PW-1:0] w_verr_d;
    logic signed [DW:0]   w_tv33;
    logic signed [DW:0]   w_lo33;
    logic signed [DW:0]   w_hi33;
    logic signed [DW:0]   w_ediff;
    logic signed [AW-1:0] w_num;

    aptc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_mreq),
        .o_res  (w_mres)
    );

    aptc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_dreq),
        .o_res  (w_dres)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovalid;
    assign o_out.thrust_out = r_othrust;
    assign o_out.saturated  = r_osat;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    // product post-processing
    assign w_mq_sat  = aptc_pkg::sat32(PW'(w_mres.q));
    assign w_mq_ovf  = aptc_pkg::ovf32(PW'(w_mres.q));
    assign w_int_sum = PW'(r_integral) + PW'(w_mq_sat);
    assign w_neg_mq  = -PW'(w_mres.q);

    // error terms
    assign w_err_d  = PW'(r_th) - PW'(r_mh);
    assign w_verr_d = PW'(r_vcmd) - PW'(r_mv);
    assign w_tv33   = (DW+1)'(r_tv);
    assign w_lo33   = -$signed({2'b00, r_desc});
    assign w_hi33   = $signed({2'b00, r_asc});
    assign w_ediff  = (DW+1)'(r_err) - (DW+1)'(r_last);
    assign w_num    = r_acc + AW'(r_ff) - AW'(aptc_pkg::K_GRAVITY);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_kp       = r_kp;
        n_kv       = r_kv;
        n_ki       = r_ki;
        n_desc     = r_desc;
        n_asc      = r_asc;
        n_mass     = r_mass;
        n_th       = r_th;
        n_tv       = r_tv;
        n_mh       = r_mh;
        n_mv       = r_mv;
        n_ff       = r_ff;
        n_bz       = r_bz;
        n_dt       = r_dt;
        n_err      = r_err;
        n_vcmd     = r_vcmd;
        n_verr     = r_verr;
        n_integral = r_integral;
        n_last     = r_last;
        n_rate     = r_rate;
        n_rate_ok  = r_rate_ok;
        n_acc      = r_acc;
        n_sat      = r_sat;
        n_mreq     = r_mreq;
        n_dreq     = r_dreq;
        n_ovalid   = r_ovalid;
        n_othrust  = r_othrust;
        n_osat     = r_osat;

        n_mreq.start = 1'b0;
        n_dreq.start = 1'b0;

        // register writes
        if (i_cfg.valid) begin
            case (i_cfg.index)
                aptc_pkg::REG_POSITION_GAIN: n_kp   = i_cfg.data;
                aptc_pkg::REG_VELOCITY_GAIN: n_kv   = i_cfg.data;
                aptc_pkg::REG_INTEGRAL_GAIN: n_ki   = i_cfg.data;
                aptc_pkg::REG_DESCENT_LIMIT: n_desc = i_cfg.data;
                aptc_pkg::REG_ASCENT_LIMIT:  n_asc  = i_cfg.data;
                aptc_pkg::REG_VEHICLE_MASS:  n_mass = i_cfg.data;
                default: ;
            endcase
        end

        // drop the result beat once taken
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        // the rate quotient lands whenever the divider finishes it
        if (w_dres.done && (r_state != S_UDIV)) begin
            n_rate    = w_dres.q;
            n_rate_ok = 1'b1;
            n_sat     = n_sat | w_dres.ovf;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_th    = i_in.target_height;
                    n_tv    = i_in.target_climb_speed;
                    n_mh    = i_in.measured_height;
                    n_mv    = i_in.measured_climb_speed;
                    n_bz    = i_in.tilt_cosine;
                    n_ff    = i_in.feedforward_accel;
                    n_dt    = i_in.time_step;
                    n_sat   = 1'b0;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_err = aptc_pkg::sat32(w_err_d);
                n_sat = n_sat | aptc_pkg::ovf32(w_err_d);
                // lower bound first, so inverted limits favor the descent limit
                if (w_tv33 < w_lo33) begin
                    n_vcmd = w_lo33[DW-1:0];
                end else if (w_tv33 > w_hi33) begin
                    n_vcmd = w_hi33[DW-1:0];
                end else begin
                    n_vcmd = r_tv;
                end
                n_state = S_VERR;
            end
            S_VERR: begin
                n_verr    = aptc_pkg::sat32(w_verr_d);
                n_sat     = n_sat | aptc_pkg::ovf32(w_verr_d);
                n_last    = r_err;
                n_rate    = '0;
                n_rate_ok = (r_dt == '0);
                if (r_dt != '0) begin
                    n_dreq.start = 1'b1;
                    n_dreq.num   = NW'($signed({w_ediff, {FW{1'b0}}}));
                    n_dreq.den   = $signed({1'b0, r_dt});
                end
                n_mreq.start = 1'b1;
                n_mreq.a     = r_err;
                n_mreq.b     = $signed({{(DW-aptc_pkg::DT_W){1'b0}}, r_dt});
                n_op         = OP_INT;
                n_state      = S_MUL;
            end
            S_MUL: begin
                if (w_mres.done) begin
                    n_sat = n_sat | w_mq_ovf;
                    case (r_op)
                        OP_INT: begin
                            n_integral   = aptc_pkg::sat32(w_int_sum);
                            n_sat        = n_sat | aptc_pkg::ovf32(w_int_sum);
                            n_mreq.start = 1'b1;
                            n_mreq.a     = $signed({1'b0, r_kp});
                            n_mreq.b     = r_err;
                            n_op         = OP_KP;
                        end
                        OP_KP: begin
                            n_acc        = AW'(w_mq_sat);
                            n_mreq.start = 1'b1;
                            n_mreq.a     = $signed({1'b0, r_kv});
                            n_mreq.b     = r_verr;
                            n_op         = OP_KV;
                        end
                        OP_KV: begin
                            n_acc        = r_acc + AW'(w_mq_sat);
                            n_mreq.start = 1'b1;
                            n_mreq.a     = $signed({1'b0, r_ki});
                            n_mreq.b     = r_integral;
                            n_op         = OP_KI;
                        end
                        OP_KI: begin
                            n_acc   = r_acc + AW'(w_mq_sat);
                            n_state = S_RATE;
                        end
                        OP_KR: begin
                            n_acc   = r_acc + AW'(w_mq_sat);
                            n_state = S_NUM;
                        end
                        OP_MASS: begin
                            // negate the unsaturated product, then clamp
                            n_sat     = r_sat | aptc_pkg::ovf32(w_neg_mq);
                            n_othrust = aptc_pkg::sat32(w_neg_mq);
                            n_state   = S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RATE: begin
                // hold until the rate quotient is in
                if (r_rate_ok) begin
                    n_mreq.start = 1'b1;
                    n_mreq.a     = aptc_pkg::K_RATE;
                    n_mreq.b     = r_rate;
                    n_op         = OP_KR;
                    n_state      = S_MUL;
                end
            end
            S_NUM: begin
                if (r_bz == '0) begin
                    n_sat     = 1'b1;
                    n_othrust = (w_num <= 0) ? aptc_pkg::S32_MAX : aptc_pkg::S32_MIN;
                    n_state   = S_OUT;
                end else begin
                    n_dreq.start = 1'b1;
                    n_dreq.num   = $signed({w_num, {FW{1'b0}}});
                    n_dreq.den   = r_bz;
                    n_state      = S_UDIV;
                end
            end
            S_UDIV: begin
                if (w_dres.done) begin
                    n_sat        = n_sat | w_dres.ovf;
                    n_mreq.start = 1'b1;
                    n_mreq.a     = w_dres.q;
                    n_mreq.b     = $signed({1'b0, r_mass});
                    n_op         = OP_MASS;
                    n_state      = S_MUL;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_ovalid = 1'b1;
                    n_osat   = r_sat;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_INT;
            r_kp         <= '0;
            r_kv         <= '0;
            r_ki         <= '0;
            r_desc       <= aptc_pkg::RST_RATE_LIMIT;
            r_asc        <= aptc_pkg::RST_RATE_LIMIT;
            r_mass       <= aptc_pkg::RST_MASS;
            r_integral   <= '0;
            r_last       <= '0;
            r_rate_ok    <= 1'b0;
            r_sat        <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_kp         <= n_kp;
            r_kv         <= n_kv;
            r_ki         <= n_ki;
            r_desc       <= n_desc;
            r_asc        <= n_asc;
            r_mass       <= n_mass;
            r_integral   <= n_integral;
            r_last       <= n_last;
            r_rate_ok    <= n_rate_ok;
            r_sat        <= n_sat;
            r_mreq.start <= n_mreq.start;
            r_dreq.start <= n_dreq.start;
            r_ovalid     <= n_ovalid;
        end
        r_th      <= n_th;
        r_tv      <= n_tv;
        r_mh      <= n_mh;
        r_mv      <= n_mv;
        r_ff      <= n_ff;
        r_bz      <= n_bz;
        r_dt      <= n_dt;
        r_err     <= n_err;
        r_vcmd    <= n_vcmd;
        r_verr    <= n_verr;
        r_rate    <= n_rate;
        r_acc     <= n_acc;
        r_mreq.a  <= n_mreq.a;
        r_mreq.b  <= n_mreq.b;
        r_dreq.num <= n_dreq.num;
        r_dreq.den <= n_dreq.den;
        r_othrust <= n_othrust;
        r_osat    <= n_osat;
    end

    // a product never comes back to an idle sequencer
    `APTC_ASSERT_NEVER(a_mul_idle, i_clk, i_rst_n, w_mres.done && (r_state == S_IDLE))
    // both divisions finish before the result step
    `APTC_ASSERT_NEVER(a_div_late, i_clk, i_rst_n, w_dres.done && ((r_state == S_IDLE) || (r_state == S_OUT)))
    // a zero tilt cosine always flags its result beat
    `APTC_ASSERT_NEXT(a_zero_tilt, i_clk, i_rst_n, w_out_load && (r_bz == '0), o_out.saturated)

endmodule
`default_nettype wire

/* dv/altitude_pid_thrust_controller_core_tb.sv */
// Self-checking testbench for altitude_pid_thrust_controller_core: a directed table,
// then randomized register settings and control ticks checked against a Q16.16 predictor.
// Depends on aptc_pkg, aptc_if and the core RTL.
`timescale 1ns / 1ps
module altitude_pid_thrust_controller_core_tb;
    import aptc_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int Q_ONE           = 65536;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int TAIL_CYCLES     = 100;   // wait after the drain, to catch stray beats
    localparam int SETTINGS_COUNT  = 10;
    localparam int TICKS_PER_SET   = 95;
    localparam int MAX_REPORTS     = 10;
    localparam int TILT_MIN        = -131072;
    localparam int TILT_MAX        = 131071;
    localparam int DT_MAX          = 131071;
    localparam logic [CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;
    // Indexes 6 and 7 decode to nothing; writing one must leave every register alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] target_height;
        logic signed [DATA_W-1:0] target_climb_speed;
        logic signed [DATA_W-1:0] measured_height;
        logic signed [DATA_W-1:0] measured_climb_speed;
        logic signed [TILT_W-1:0] tilt_cosine;
        logic signed [DATA_W-1:0] feedforward_accel;
        logic        [DT_W-1:0]   time_step;
    } tick_t;

    typedef struct {
        logic signed [DATA_W-1:0] thrust;
        bit                       sat;
    } thrust_beat_t;

    typedef enum {ROW_TICK, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e                kind;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_W-1:0]         reg_data;
        tick_t                    tick;
        bit                       typed;   // expected thrust written into the row
        logic signed [DATA_W-1:0] thrust;
        bit                       sat;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    aptc_in_if  tick_bus ();
    aptc_out_if thrust_bus ();
    aptc_cfg_if reg_bus ();

    altitude_pid_thrust_controller_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_bus),
        .o_out   (thrust_bus),
        .i_cfg   (reg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor copy of the registers and the loop state
    longint gain_pos, gain_vel, gain_int, descent_lim, ascent_lim, mass_q;
    longint integ_acc, prev_height_err;

    thrust_beat_t awaited_thrust[$];
    stim_row_t    directed_rows[$];

    bit steady_in  = 1'b0;   // no sender gaps in this stretch
    bit steady_out = 1'b0;   // no receiver stalls in this stretch
    int fail_count      = 0;
    int ticks_sent      = 0;
    int writes_done     = 0;
    int results_seen    = 0;
    int clipped_results = 0;
    int cycle_count     = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_s32(input longint v, inout bit clip);
        if (v > LIM_HI) begin
            clip = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            clip = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    // Q16.16 product, truncated toward zero, then clamped
    function automatic longint qmul(input longint a, input longint b, inout bit clip);
        return clamp_s32((a * b) / Q_ONE, clip);
    endfunction

    // Work out the thrust beat of one tick and advance the integrator and last error
    function automatic void predict_thrust(input tick_t t, output thrust_beat_t r);
        longint dt, tilt, err, err_rate, vcmd, verr, integ_step;
        longint p_term, v_term, d_term, i_term, num, u1, thrust;
        bit clip;
        clip = 1'b0;
        dt   = longint'(t.time_step);
        tilt = longint'(t.tilt_cosine);
        err  = clamp_s32(longint'(t.target_height) - longint'(t.measured_height), clip);
        // Zero time step: no rate term, no integration, no flag
        err_rate = 0;
        if (dt != 0) begin
            err_rate = clamp_s32(((err - prev_height_err) * Q_ONE) / dt, clip);
        end
        // Lower bound is tested first, so it wins when the limits cross
        vcmd = longint'(t.target_climb_speed);
        if (vcmd < -descent_lim) begin
            vcmd = -descent_lim;
        end else if (vcmd > ascent_lim) begin
            vcmd = ascent_lim;
        end
        verr = clamp_s32(vcmd - longint'(t.measured_climb_speed), clip);
        integ_step = qmul(err, dt, clip);
        integ_acc = clamp_s32(integ_acc + integ_step, clip);
        prev_height_err = err;
        p_term = qmul(gain_pos, err, clip);
        v_term = qmul(gain_vel, verr, clip);
        d_term = qmul(longint'(K_RATE), err_rate, clip);
        i_term = qmul(gain_int, integ_acc, clip);
        num = p_term + v_term + d_term + i_term + longint'(t.feedforward_accel)
            - longint'(K_GRAVITY);
        if (tilt == 0) begin
            // Division by zero tilt: saturate toward the sign of the command
            clip = 1'b1;
            thrust = (num <= 0) ? LIM_HI : LIM_LO;
        end else begin
            u1 = clamp_s32((num * Q_ONE) / tilt, clip);
            thrust = clamp_s32(-((u1 * mass_q) / Q_ONE), clip);
        end
        r.thrust = thrust[DATA_W-1:0];
        r.sat = clip;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_cycles(input bit steady);
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void add_tick(
        input logic signed [DATA_W-1:0] th, input logic signed [DATA_W-1:0] tv,
        input logic signed [DATA_W-1:0] mh, input logic signed [DATA_W-1:0] mv,
        input logic signed [TILT_W-1:0] tilt, input logic signed [DATA_W-1:0] ff,
        input logic [DT_W-1:0] dt, input bit typed,
        input logic signed [DATA_W-1:0] thrust, input bit sat);
        stim_row_t row;
        row.kind = ROW_TICK;
        row.reg_index = '0;
        row.reg_data = '0;
        row.tick.target_height = th;
        row.tick.target_climb_speed = tv;
        row.tick.measured_height = mh;
        row.tick.measured_climb_speed = mv;
        row.tick.tilt_cosine = tilt;
        row.tick.feedforward_accel = ff;
        row.tick.time_step = dt;
        row.typed = typed;
        row.thrust = thrust;
        row.sat = sat;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data = val;
        row.tick = '{default: '0};
        row.typed = 1'b0;
        row.thrust = '0;
        row.sat = 1'b0;
        directed_rows.push_back(row);
    endfunction

    // Register value: extremes, raw noise, or a value a tuned vehicle would use
    function automatic logic [CFG_W-1:0] draw_reg(input logic [CFG_IDX_W-1:0] idx);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_MAX;
            2: return CFG_W'($urandom());
            default: begin
                case (idx)
                    REG_POSITION_GAIN: return CFG_W'($urandom_range(0, 10 * Q_ONE));
                    REG_VELOCITY_GAIN: return CFG_W'($urandom_range(0, 10 * Q_ONE));
                    REG_INTEGRAL_GAIN: return CFG_W'($urandom_range(0, 5 * Q_ONE));
                    REG_DESCENT_LIMIT: return CFG_W'($urandom_range(0, 20 * Q_ONE));
                    REG_ASCENT_LIMIT:  return CFG_W'($urandom_range(0, 20 * Q_ONE));
                    default:           return CFG_W'($urandom_range(Q_ONE / 10, 5 * Q_ONE));
                endcase
            end
        endcase
    endfunction

    // Mostly plausible flight ticks with random content; the rest raw full-width noise
    function automatic tick_t draw_tick(input bit wild);
        tick_t t;
        if (wild) begin
            t.target_height        = $urandom();
            t.target_climb_speed   = $urandom();
            t.measured_height      = $urandom();
            t.measured_climb_speed = $urandom();
            t.tilt_cosine          = TILT_W'($urandom());
            t.feedforward_accel    = $urandom();
            t.time_step            = DT_W'($urandom());
            case ($urandom_range(0, 3))
                0: t.tilt_cosine = '0;
                1: t.time_step = '0;
                default: ;
            endcase
        end else begin
            t.target_height        = int'($urandom_range(0, 100 * Q_ONE)) - 50 * Q_ONE;
            t.measured_height      = t.target_height
                                   + int'($urandom_range(0, 10 * Q_ONE)) - 5 * Q_ONE;
            t.target_climb_speed   = int'($urandom_range(0, 40 * Q_ONE)) - 20 * Q_ONE;
            t.measured_climb_speed = int'($urandom_range(0, 30 * Q_ONE)) - 15 * Q_ONE;
            t.tilt_cosine          = TILT_W'($urandom_range(Q_ONE / 2, Q_ONE));
            if ($urandom_range(0, 11) == 0) begin
                t.tilt_cosine = -t.tilt_cosine;
            end
            t.feedforward_accel    = int'($urandom_range(0, 10 * Q_ONE)) - 5 * Q_ONE;
            t.time_step            = DT_W'($urandom_range(1, 3277));
            case ($urandom_range(0, 19))
                0: t.tilt_cosine = '0;
                1: t.time_step = '0;
                default: ;
            endcase
        end
        return t;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
    endtask

    // Send one tick beat; push the typed or predicted thrust when it is accepted
    task automatic send_tick(input tick_t t, input bit typed,
                             input logic signed [DATA_W-1:0] thrust, input bit sat);
        thrust_beat_t want;
        int gap;
        gap = idle_cycles(steady_in);
        if (gap > 0) begin
            tick_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_bus.target_height        = t.target_height;
        tick_bus.target_climb_speed   = t.target_climb_speed;
        tick_bus.measured_height      = t.measured_height;
        tick_bus.measured_climb_speed = t.measured_climb_speed;
        tick_bus.tilt_cosine          = t.tilt_cosine;
        tick_bus.feedforward_accel    = t.feedforward_accel;
        tick_bus.time_step            = t.time_step;
        tick_bus.valid                = 1'b1;
        do @(posedge clk); while (tick_bus.ready !== 1'b1);
        predict_thrust(t, want);
        if (typed) begin
            want.thrust = thrust;
            want.sat = sat;
        end
        awaited_thrust.push_back(want);
        ticks_sent++;
        // Hold valid high; the next call drops it if it draws a gap
        @(negedge clk);
    endtask

    // Drop valid and hold until every awaited thrust beat has come back
    task automatic drain_ticks();
        tick_bus.valid = 1'b0;
        while (awaited_thrust.size() != 0) @(negedge clk);
    endtask

    // Register write; only called once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        reg_bus.index = idx;
        reg_bus.data  = val;
        reg_bus.valid = 1'b1;
        do @(posedge clk); while (reg_bus.ready !== 1'b1);
        case (idx)
            REG_POSITION_GAIN: gain_pos    = longint'(val);
            REG_VELOCITY_GAIN: gain_vel    = longint'(val);
            REG_INTEGRAL_GAIN: gain_int    = longint'(val);
            REG_DESCENT_LIMIT: descent_lim = longint'(val);
            REG_ASCENT_LIMIT:  ascent_lim  = longint'(val);
            REG_VEHICLE_MASS:  mass_q      = longint'(val);
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        reg_bus.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped by the cycle watchdog after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Thrust receiver: random stalls, compare each beat with the oldest expectation
    // ------------------------------------------------------------------
    initial begin : thrust_receiver
        thrust_beat_t want;
        int stall;
        thrust_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = idle_cycles(steady_out);
            if (stall > 0) begin
                thrust_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            thrust_bus.ready = 1'b1;
            do @(posedge clk); while (thrust_bus.valid !== 1'b1);
            results_seen++;
            if (thrust_bus.saturated === 1'b1) begin
                clipped_results++;
            end
            if (awaited_thrust.size() == 0) begin
                log_failure($sformatf("thrust beat with nothing awaited: thrust %0d sat %b",
                                      thrust_bus.thrust_out, thrust_bus.saturated));
            end else begin
                want = awaited_thrust.pop_front();
                if (thrust_bus.thrust_out !== want.thrust) begin
                    log_failure($sformatf("thrust_out: expected %0d (%08h), got %0d (%08h)",
                                          want.thrust, want.thrust,
                                          thrust_bus.thrust_out, thrust_bus.thrust_out));
                end
                if (thrust_bus.saturated !== want.sat) begin
                    log_failure($sformatf("saturated: expected %b, got %b (thrust %0d)",
                                          want.sat, thrust_bus.saturated, want.thrust));
                end
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        tick_t t;
        int directed_ticks;
        bit write_unused;

        // Drive every input to a known value from time zero
        tick_bus.valid                = 1'b0;
        tick_bus.target_height        = '0;
        tick_bus.target_climb_speed   = '0;
        tick_bus.measured_height      = '0;
        tick_bus.measured_climb_speed = '0;
        tick_bus.tilt_cosine          = '0;
        tick_bus.feedforward_accel    = '0;
        tick_bus.time_step            = '0;
        reg_bus.valid = 1'b0;
        reg_bus.index = '0;
        reg_bus.data  = '0;

        gain_pos        = 0;
        gain_vel        = 0;
        gain_int        = 0;
        descent_lim     = longint'(RST_RATE_LIMIT);
        ascent_lim      = longint'(RST_RATE_LIMIT);
        mass_q          = longint'(RST_MASS);
        integ_acc       = 0;
        prev_height_err = 0;

        // Directed table. Reset setting first: gains zero and unit mass, so the
        // thrust is minus (ff - gravity) / tilt and can be typed in.
        //       th       tv       mh       mv       tilt      ff       dt     typ thrust  sat
        add_tick(0,       0,       0,       0,       Q_ONE,    0,       Q_ONE, 1, 642908, 0);
        // zero tilt cosine: sign of the command picks the rail
        add_tick(0,       0,       0,       0,       0,        0,       Q_ONE, 1, S32_MAX, 1);
        add_tick(0,       0,       0,       0,       0,        642909,  Q_ONE, 1, S32_MIN, 1);
        add_tick(0,       0,       0,       0,       0,        642908,  0,     1, S32_MAX, 1);
        // feed-forward extremes
        add_tick(0,       0,       0,       0,       Q_ONE,    S32_MAX, 0,     1,
                 -32'sd2146840739, 0);
        add_tick(0,       0,       0,       0,       Q_ONE,    S32_MIN, Q_ONE, 1, S32_MAX, 1);
        // inverted, tiny and most negative tilt cosines
        add_tick(0,       0,       0,       0,       -Q_ONE,   0,       Q_ONE, 1, -642908, 0);
        add_tick(0,       0,       0,       0,       1,        0,       Q_ONE, 1, S32_MAX, 1);
        add_tick(0,       0,       0,       0,       TILT_MIN, 0,       Q_ONE, 1, -321454, 0);

        add_write(REG_POSITION_GAIN, Q_ONE);
        add_write(REG_VELOCITY_GAIN, 2 * Q_ONE);
        add_write(REG_INTEGRAL_GAIN, Q_ONE / 2);
        add_write(REG_DESCENT_LIMIT, 2 * Q_ONE);
        add_write(REG_ASCENT_LIMIT, 3 * Q_ONE);
        add_write(REG_VEHICLE_MASS, 2 * Q_ONE);
        add_tick(10 * Q_ONE, 0,    0,       0,       Q_ONE,    0,       655,   0, 0, 0);
        // climb target clamped by the ascent and the descent limit
        add_tick(0,       S32_MAX, 0,       0,       Q_ONE,    0,       655,   0, 0, 0);
        add_tick(0,       S32_MIN, 0,       Q_ONE,   Q_ONE,    0,       655,   0, 0, 0);
        // position error saturates, then the error rate on the full swing
        add_tick(S32_MIN, 0,       S32_MAX, 0,       Q_ONE,    0,       Q_ONE, 0, 0, 0);
        add_tick(S32_MAX, 0,       S32_MIN, 0,       Q_ONE,    0,       Q_ONE, 0, 0, 0);
        // zero and out-of-range time step, out-of-range tilt
        add_tick(5 * Q_ONE, 0,     0,       0,       Q_ONE,    0,       0,     0, 0, 0);
        add_tick(Q_ONE,   0,       0,       0,       Q_ONE,    0,       DT_MAX, 0, 0, 0);
        add_tick(0,       Q_ONE,   0,       0,       TILT_MAX, 0,       655,   0, 0, 0);
        // velocity error saturates
        add_tick(0,       S32_MAX, 0,       S32_MIN, -Q_ONE,   0,       655,   0, 0, 0);
        // both rate limits zero: the clamp pins the climb target to zero
        add_write(REG_DESCENT_LIMIT, '0);
        add_write(REG_ASCENT_LIMIT, '0);
        add_tick(0,       5 * Q_ONE, 0,     0,       Q_ONE,    0,       655,   0, 0, 0);
        add_tick(0,       -5 * Q_ONE, 0,    Q_ONE,   Q_ONE,    0,       655,   0, 0, 0);
        // largest gains and mass: gain products saturate
        add_write(REG_POSITION_GAIN, CFG_MAX);
        add_write(REG_VELOCITY_GAIN, CFG_MAX);
        add_write(REG_INTEGRAL_GAIN, CFG_MAX);
        add_write(REG_VEHICLE_MASS, CFG_MAX);
        add_tick(Q_ONE,   Q_ONE,   0,       0,       Q_ONE,    Q_ONE,   655,   0, 0, 0);
        add_tick(S32_MAX, S32_MAX, S32_MIN, S32_MIN, TILT_MAX, S32_MAX, DT_MAX, 0, 0, 0);
        // zero mass, and a write to an index that decodes to nothing
        add_write(REG_VEHICLE_MASS, '0);
        add_write(REG_UNUSED, CFG_MAX);
        add_tick(Q_ONE,   0,       0,       0,       Q_ONE,    0,       655,   0, 0, 0);

        // Reset: asserted from time zero, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain_ticks();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end else begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed,
                          directed_rows[i].thrust, directed_rows[i].sat);
            end
        end
        directed_ticks = ticks_sent;

        // Random part: each setting starts from an idle block (the sender pauses
        // until every thrust beat is back), then streams ticks at random pace.
        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            drain_ticks();
            write_unused = ($urandom_range(0, 3) == 0);
            for (int r = REG_POSITION_GAIN; r <= REG_VEHICLE_MASS; r++) begin
                if (s == 0) begin
                    write_reg(r, CFG_MAX);
                end else if (s == 1) begin
                    write_reg(r, '0);
                end else begin
                    write_reg(r, draw_reg(r));
                end
            end
            if (write_unused) begin
                write_reg(REG_UNUSED, CFG_W'($urandom()));
            end
            steady_in  = ($urandom_range(0, 3) == 0);
            steady_out = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < TICKS_PER_SET; n++) begin
                t = draw_tick($urandom_range(0, 5) == 0);
                send_tick(t, 1'b0, '0, 1'b0);
            end
        end

        // Wind down: everything back, then watch for stray beats
        drain_ticks();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_thrust.size() != 0) begin
            log_failure($sformatf("%0d thrust beats never arrived", awaited_thrust.size()));
        end

        $display("Covered %0d control ticks (%0d from the directed table) over %0d settings,",
                 ticks_sent, directed_ticks, SETTINGS_COUNT + 1);
        $display("%0d register writes; %0d thrust beats checked, %0d with the flag set",
                 writes_done, results_seen, clipped_results);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* altitude_pid_thrust_controller_core.f */
+incdir+rtl
rtl/aptc_pkg.sv
rtl/aptc_if.sv
rtl/aptc_mul.sv
rtl/aptc_div.sv
rtl/altitude_pid_thrust_controller_core.sv
dv/altitude_pid_thrust_controller_core_tb.sv
